// ===== rtl/emg_pkg.sv =====
// Shared widths, register indexes and request structs of the ElGamal block.
// No dependencies; every other file imports this package.
package emg_pkg;

    localparam int MOD_BITS  = 32;
    localparam int FIELD_W   = 32;
    localparam int CNT_W     = $clog2(FIELD_W + 1);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = CFG_IDX_W'(1);

    localparam logic [FIELD_W-1:0] MODULUS_RST   = FIELD_W'(23);
    localparam logic [FIELD_W-1:0] GENERATOR_RST = FIELD_W'(5);

    // Request to the serial modular multiplier: result = a * b mod q, a < q.
    typedef struct packed {
        logic                start;
        logic [MOD_BITS-1:0] a;
        logic [FIELD_W-1:0]  b;
    } mm_req_t;

    // Request to the serial divider.
    typedef struct packed {
        logic                start;
        logic [MOD_BITS-1:0] dividend;
        logic [MOD_BITS-1:0] divisor;
    } dv_req_t;

endpackage

// ===== rtl/emg_modmul.sv =====
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
// Depends on emg_pkg.
module emg_modmul
    import emg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  mm_req_t             req,
    input  logic [MOD_BITS-1:0] q,
    output logic                done,
    output logic [MOD_BITS-1:0] result
);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MOD_BITS-1:0] r_reg;
    logic [MOD_BITS-1:0] a_reg;
    logic [FIELD_W-1:0]  b_reg;

    logic [MOD_BITS:0] dbl;
    logic [MOD_BITS:0] red1;
    logic [MOD_BITS:0] sum;
    logic [MOD_BITS:0] r_next;

    // r = 2r mod q, then add a when the multiplier bit is set
    always_comb
    begin
        dbl    = {r_reg, 1'b0};
        red1   = (dbl >= {1'b0, q}) ? dbl - {1'b0, q} : dbl;
        sum    = red1 + (b_reg[FIELD_W-1] ? {1'b0, a_reg} : '0);
        r_next = (sum >= {1'b0, q}) ? sum - {1'b0, q} : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FIELD_W);
                r_reg    <= '0;
                a_reg    <= req.a;
                b_reg    <= req.b;
            end
            else if (busy_reg)
            begin
                r_reg   <= r_next[MOD_BITS-1:0];
                b_reg   <= {b_reg[FIELD_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// ===== rtl/emg_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on emg_pkg.
module emg_div
    import emg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dv_req_t             req,
    output logic                done,
    output logic [MOD_BITS-1:0] quotient,
    output logic [MOD_BITS-1:0] remainder
);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MOD_BITS-1:0] dvd_reg;
    logic [MOD_BITS-1:0] dvs_reg;
    logic [MOD_BITS-1:0] quo_reg;
    logic [MOD_BITS-1:0] rem_reg;

    logic [MOD_BITS:0] shifted;
    logic              ge;
    logic [MOD_BITS:0] diff;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[MOD_BITS-1]};
        ge      = (shifted >= {1'b0, dvs_reg});
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MOD_BITS);
                dvd_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                quo_reg  <= '0;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[MOD_BITS-1:0] : shifted[MOD_BITS-1:0];
                quo_reg <= {quo_reg[MOD_BITS-2:0], ge};
                dvd_reg <= {dvd_reg[MOD_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/elgamal_encrypt_decrypt.sv =====
// Top level of the ElGamal encrypt/decrypt block: sequencer, config and output register.
// Depends on emg_pkg, emg_modmul and emg_div.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one beat of private_key,
//   nonce and message. Response channel (rsp_valid/rsp_ready) returns one
//   beat of public_key, cipher_first, cipher_second, recovered_message and
//   no_inverse for every request beat, in order.
//   Configuration: cfg_write with cfg_index 0 loads the modulus, index 1 the
//   generator; other indexes are ignored. Write only while the block is idle.
//   Sequence: every modular product runs on one bit-serial multiplier. Two
//   input reductions, four exponentiations of FIELD_W bits (one square plus
//   one multiply per set exponent bit), one product for C2, the extended
//   Euclid loop (one serial division plus one product per step, up to about
//   46 steps at 32 bits) and the final product when an inverse exists. A
//   zero modulus goes straight to the response. One request is processed at
//   a time.
//   Reset: modulus returns to 23, generator to 5, no response is pending.
//   Stall: a finished result waits in the output register; the next request
//   is taken meanwhile, and its result holds until the register empties.
module elgamal_encrypt_decrypt
    import emg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [FIELD_W-1:0]   private_key,
    input  logic [FIELD_W-1:0]   nonce,
    input  logic [FIELD_W-1:0]   message,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [FIELD_W-1:0]   public_key,
    output logic [FIELD_W-1:0]   cipher_first,
    output logic [FIELD_W-1:0]   cipher_second,
    output logic [FIELD_W-1:0]   recovered_message,
    output logic                 no_inverse
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RED_G,
        S_RED_M,
        S_POW_INIT,
        S_POW_MUL,
        S_POW_SQR,
        S_POW_END,
        S_C2,
        S_INV_CHK,
        S_DIV,
        S_INV_MUL,
        S_M2,
        S_OUT
    } state_t;

    state_t state_reg;

    logic [FIELD_W-1:0]  mod_cfg_reg;
    logic [FIELD_W-1:0]  gen_cfg_reg;
    logic [FIELD_W-1:0]  x_reg;
    logic [FIELD_W-1:0]  k_reg;
    logic [FIELD_W-1:0]  m_reg;
    logic [MOD_BITS-1:0] gr_reg;
    logic [MOD_BITS-1:0] mr_reg;
    logic [MOD_BITS-1:0] y_reg;
    logic [MOD_BITS-1:0] c1_reg;
    logic [MOD_BITS-1:0] c2_reg;
    logic [MOD_BITS-1:0] m2_reg;
    logic                ok_reg;
    logic [MOD_BITS-1:0] pw_base_reg;
    logic [FIELD_W-1:0]  pw_exp_reg;
    logic [MOD_BITS-1:0] pw_res_reg;
    logic [CNT_W-1:0]    pw_cnt_reg;
    logic [1:0]          pw_sel_reg;
    logic [MOD_BITS-1:0] a2_reg;
    logic [MOD_BITS-1:0] a3_reg;
    logic [MOD_BITS-1:0] b2_reg;
    logic [MOD_BITS-1:0] b3_reg;
    logic [MOD_BITS-1:0] t_reg;
    logic [MOD_BITS-1:0] rem_reg;
    logic                wait_reg;
    mm_req_t             mm_req_reg;
    dv_req_t             dv_req_reg;

    logic                rsp_valid_reg;
    logic [FIELD_W-1:0]  pk_out_reg;
    logic [FIELD_W-1:0]  c1_out_reg;
    logic [FIELD_W-1:0]  c2_out_reg;
    logic [FIELD_W-1:0]  m2_out_reg;
    logic                ninv_out_reg;

    logic [MOD_BITS-1:0] q;
    logic [MOD_BITS-1:0] one_q;
    logic                mm_done;
    logic [MOD_BITS-1:0] mm_result;
    logic                dv_done;
    logic [MOD_BITS-1:0] dv_quo;
    logic [MOD_BITS-1:0] dv_rem;
    logic [MOD_BITS-1:0] n2;

    // Only the low MOD_BITS of the modulus take part; 1 mod q is 0 when q is 1
    assign q     = mod_cfg_reg[MOD_BITS-1:0];
    assign one_q = (q == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    // New Bezout coefficient a2 - b2*t, kept as a residue mod q
    assign n2 = a2_reg - mm_result + ((a2_reg < mm_result) ? q : '0);

    emg_modmul u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req_reg),
        .q      (q),
        .done   (mm_done),
        .result (mm_result)
    );

    emg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (dv_req_reg),
        .done      (dv_done),
        .quotient  (dv_quo),
        .remainder (dv_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            mod_cfg_reg      <= MODULUS_RST;
            gen_cfg_reg      <= GENERATOR_RST;
            wait_reg         <= 1'b0;
            mm_req_reg.start <= 1'b0;
            dv_req_reg.start <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            pw_sel_reg       <= '0;
        end
        else
        begin
            mm_req_reg.start <= 1'b0;
            dv_req_reg.start <= 1'b0;

            if (cfg_write)
            begin
                if (cfg_index == CFG_MODULUS)
                    mod_cfg_reg <= cfg_data;
                else if (cfg_index == CFG_GENERATOR)
                    gen_cfg_reg <= cfg_data;
            end

            // drop the response beat once taken
            if (rsp_valid_reg && rsp_ready)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        x_reg    <= private_key;
                        k_reg    <= nonce;
                        m_reg    <= message;
                        wait_reg <= 1'b0;
                        if (q == '0)
                        begin
                            // zero modulus: all values zero, no inverse
                            y_reg     <= '0;
                            c1_reg    <= '0;
                            c2_reg    <= '0;
                            m2_reg    <= '0;
                            ok_reg    <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_RED_G;
                    end
                end

                S_RED_G:
                begin
                    if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: one_q, b: gen_cfg_reg};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        gr_reg    <= mm_result;
                        wait_reg  <= 1'b0;
                        state_reg <= S_RED_M;
                    end
                end

                S_RED_M:
                begin
                    if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: one_q, b: m_reg};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        mr_reg     <= mm_result;
                        wait_reg   <= 1'b0;
                        pw_sel_reg <= 2'd0;
                        state_reg  <= S_POW_INIT;
                    end
                end

                S_POW_INIT:
                begin
                    unique case (pw_sel_reg)
                        2'd0:
                        begin
                            pw_base_reg <= gr_reg;
                            pw_exp_reg  <= x_reg;
                        end
                        2'd1:
                        begin
                            pw_base_reg <= gr_reg;
                            pw_exp_reg  <= k_reg;
                        end
                        2'd2:
                        begin
                            pw_base_reg <= y_reg;
                            pw_exp_reg  <= k_reg;
                        end
                        default:
                        begin
                            pw_base_reg <= c1_reg;
                            pw_exp_reg  <= x_reg;
                        end
                    endcase
                    pw_res_reg <= one_q;
                    pw_cnt_reg <= CNT_W'(FIELD_W);
                    state_reg  <= S_POW_MUL;
                end

                S_POW_MUL:
                begin
                    if (!pw_exp_reg[0])
                        state_reg <= S_POW_SQR;
                    else if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: pw_res_reg,
                                        b: FIELD_W'(pw_base_reg)};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        pw_res_reg <= mm_result;
                        wait_reg   <= 1'b0;
                        state_reg  <= S_POW_SQR;
                    end
                end

                S_POW_SQR:
                begin
                    if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: pw_base_reg,
                                        b: FIELD_W'(pw_base_reg)};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        pw_base_reg <= mm_result;
                        pw_exp_reg  <= {1'b0, pw_exp_reg[FIELD_W-1:1]};
                        pw_cnt_reg  <= pw_cnt_reg - CNT_W'(1);
                        wait_reg    <= 1'b0;
                        if (pw_cnt_reg == CNT_W'(1))
                            state_reg <= S_POW_END;
                        else
                            state_reg <= S_POW_MUL;
                    end
                end

                S_POW_END:
                begin
                    unique case (pw_sel_reg)
                        2'd0:
                        begin
                            y_reg      <= pw_res_reg;
                            pw_sel_reg <= 2'd1;
                            state_reg  <= S_POW_INIT;
                        end
                        2'd1:
                        begin
                            c1_reg     <= pw_res_reg;
                            pw_sel_reg <= 2'd2;
                            state_reg  <= S_POW_INIT;
                        end
                        2'd2:
                        begin
                            // hold y^k in c2_reg until the message product
                            c2_reg    <= pw_res_reg;
                            state_reg <= S_C2;
                        end
                        default:
                        begin
                            a2_reg    <= '0;
                            a3_reg    <= q;
                            b2_reg    <= one_q;
                            b3_reg    <= pw_res_reg;
                            state_reg <= S_INV_CHK;
                        end
                    endcase
                end

                S_C2:
                begin
                    if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: c2_reg, b: FIELD_W'(mr_reg)};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        c2_reg     <= mm_result;
                        wait_reg   <= 1'b0;
                        pw_sel_reg <= 2'd3;
                        state_reg  <= S_POW_INIT;
                    end
                end

                S_INV_CHK:
                begin
                    if (b3_reg == '0 || b3_reg == MOD_BITS'(1))
                    begin
                        ok_reg    <= (b3_reg == MOD_BITS'(1));
                        state_reg <= S_M2;
                    end
                    else
                        state_reg <= S_DIV;
                end

                S_DIV:
                begin
                    if (!wait_reg)
                    begin
                        dv_req_reg <= '{start: 1'b1, dividend: a3_reg, divisor: b3_reg};
                        wait_reg   <= 1'b1;
                    end
                    else if (dv_done)
                    begin
                        t_reg     <= dv_quo;
                        rem_reg   <= dv_rem;
                        wait_reg  <= 1'b0;
                        state_reg <= S_INV_MUL;
                    end
                end

                S_INV_MUL:
                begin
                    if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: b2_reg, b: FIELD_W'(t_reg)};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        a2_reg    <= b2_reg;
                        a3_reg    <= b3_reg;
                        b2_reg    <= n2;
                        b3_reg    <= rem_reg;
                        wait_reg  <= 1'b0;
                        state_reg <= S_INV_CHK;
                    end
                end

                S_M2:
                begin
                    if (!ok_reg)
                    begin
                        m2_reg    <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (!wait_reg)
                    begin
                        mm_req_reg <= '{start: 1'b1, a: c2_reg, b: FIELD_W'(b2_reg)};
                        wait_reg   <= 1'b1;
                    end
                    else if (mm_done)
                    begin
                        m2_reg    <= mm_result;
                        wait_reg  <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    // advance only when the output register is free or its beat is being taken
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        pk_out_reg    <= FIELD_W'(y_reg);
                        c1_out_reg    <= FIELD_W'(c1_reg);
                        c2_out_reg    <= FIELD_W'(c2_reg);
                        m2_out_reg    <= FIELD_W'(m2_reg);
                        ninv_out_reg  <= !ok_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign req_ready         = (state_reg == S_IDLE);
    assign rsp_valid         = rsp_valid_reg;
    assign public_key        = pk_out_reg;
    assign cipher_first      = c1_out_reg;
    assign cipher_second     = c2_out_reg;
    assign recovered_message = m2_out_reg;
    assign no_inverse        = ninv_out_reg;

    // Exponentiation operands stay reduced
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POW_MUL || state_reg == S_POW_SQR)
            |-> (pw_res_reg < q && pw_base_reg < q))
        else $error("exponentiation operand not reduced");

    // A product result only arrives when one was requested
    assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> wait_reg)
        else $error("unexpected multiplier completion");

    // Bezout coefficient stays a residue during the inverse loop
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INV_MUL) |-> (b2_reg < q))
        else $error("inverse coefficient out of range");

    // A missing inverse always yields a zero message
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && no_inverse) |-> (recovered_message == '0))
        else $error("nonzero message without inverse");

endmodule
